// ===== src/nvis_pkg.sv =====
// Package for the nearest value index search block.
// Holds the item mode codes and the reset entry count shared by the design; no dependencies.
package nvis_pkg;

   // Meaning of the mode field of an input item.
   typedef enum logic {
      MODE_LOAD  = 1'b0,
      MODE_QUERY = 1'b1
   } mode_type;

   // Table entry count after reset.
   localparam int unsigned ENTRY_COUNT_RESET = 1;

endpackage

// ===== src/nearest_value_index_search.sv =====
// Nearest value index search: top level with the table memory and search sequencer.
// Depends on nvis_pkg for the item mode codes and the reset entry count.
//
// The block keeps a table of signed values in ascending order, loaded one entry per item
// (mode load, at req_address), and answers a query item with the index of the entry
// nearest in value to req_value among the first entry_count entries. A load gives no result
// item; it is also taken while an earlier result still waits on the response side. A query
// search ends early when the probe stops early or a midpoint matches, and its result may
// wait for the output register. The block is not ready for another item until the query
// has moved its result into the output register. The search is bound by the single table
// read port: it reads one entry at a time, first doubling a probe index (1, 2, 4, ...)
// until it meets an entry not below the value or the doubled index would pass the last
// entry in use, then halving the bracket step by step (new midpoint, then its read). A
// last pair of reads compares the distances of the two bracket ends through one shared
// subtractor, and equal distances go to the lower index. Table entries come out of reset
// undefined and must be loaded before a query reads them; entry_count is clamped to the
// range 1 to TABLE_DEPTH.
module nearest_value_index_search #(
   parameter int unsigned TABLE_DEPTH = 1024,
   parameter int unsigned VALUE_WIDTH = 32,
   localparam int unsigned ADDR_W     = $clog2(TABLE_DEPTH),
   localparam int unsigned CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   // Configuration port
   input  logic                          csr_wr_en,
   input  logic [CNT_W-1:0]              csr_wr_data,
   // Request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic [ADDR_W-1:0]             req_address,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   // Response channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ADDR_W-1:0]             rsp_nearest_index
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIRST,
      S_PROBE,
      S_BSTEP,
      S_BIN,
      S_LO,
      S_HI,
      S_DONE
   } state_type;

   // Table memory: one write port for loads, one registered read port for the search.
   logic signed [VALUE_WIDTH-1:0] table_mem [TABLE_DEPTH];
   logic signed [VALUE_WIDTH-1:0] rd_data_ff;
   logic [ADDR_W-1:0]             rd_addr_in;
   logic                          wr_en;

   state_type                     state_ff, state_in;
   logic [CNT_W-1:0]              entry_count_ff, entry_count_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic signed [VALUE_WIDTH-1:0] key_ff, key_in;
   logic [ADDR_W-1:0]             lo_ff, lo_in;
   logic [ADDR_W-1:0]             hi_ff, hi_in;
   logic [ADDR_W-1:0]             mid_ff, mid_in;
   logic [ADDR_W-1:0]             res_ff, res_in;
   logic [VALUE_WIDTH-1:0]        dist_lo_ff, dist_lo_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]             rsp_index_ff, rsp_index_in;

   logic                          req_accept;
   logic [CNT_W-1:0]              cnt_clamped;
   logic [ADDR_W:0]               hi_doubled;
   logic [ADDR_W:0]               bracket_sum;
   logic                          bracket_open;
   logic signed [VALUE_WIDTH:0]   diff;
   logic [VALUE_WIDTH:0]          diff_mag;
   logic [VALUE_WIDTH-1:0]        dist_now;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign wr_en      = req_accept && (req_mode == nvis_pkg::MODE_LOAD)
                       && ({1'b0, req_address} < (ADDR_W + 1)'(TABLE_DEPTH));

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_nearest_index = rsp_index_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[req_address] <= req_value;
      end
      rd_data_ff <= table_mem[rd_addr_in];
   end

   // A count of zero means one entry; a count beyond the table means the whole table.
   always_comb begin
      if (entry_count_ff == '0) begin
         cnt_clamped = CNT_W'(1);
      end else if (entry_count_ff > CNT_W'(TABLE_DEPTH)) begin
         cnt_clamped = CNT_W'(TABLE_DEPTH);
      end else begin
         cnt_clamped = entry_count_ff;
      end
   end

   // Shared distance unit: exact magnitude of the entry just read minus the query value,
   // formed one bit wider so that it never overflows.
   assign diff     = $signed({rd_data_ff[VALUE_WIDTH-1], rd_data_ff})
                     - $signed({key_ff[VALUE_WIDTH-1], key_ff});
   assign diff_mag = diff[VALUE_WIDTH] ? (VALUE_WIDTH + 1)'(-diff) : diff;
   assign dist_now = diff_mag[VALUE_WIDTH-1:0];

   assign hi_doubled   = {hi_ff, 1'b0};
   assign bracket_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign bracket_open = (({1'b0, lo_ff} + (ADDR_W + 1)'(1)) < {1'b0, hi_ff});

   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      cnt_in         = cnt_ff;
      key_in         = key_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      mid_in         = mid_ff;
      res_in         = res_ff;
      dist_lo_in     = dist_lo_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_index_in   = rsp_index_ff;
      rd_addr_in     = '0;

      if (csr_wr_en) begin
         entry_count_in = csr_wr_data;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_mode == nvis_pkg::MODE_QUERY)) begin
               key_in = req_value;
               cnt_in = cnt_clamped;
               if (cnt_clamped == CNT_W'(1)) begin
                  res_in   = '0;
                  state_in = S_DONE;
               end else begin
                  state_in = S_FIRST;
               end
            end
         end
         S_FIRST: begin
            // Entry 0 is in rd_data_ff.
            if (rd_data_ff >= key_ff) begin
               res_in   = '0;
               state_in = S_DONE;
            end else begin
               hi_in      = ADDR_W'(1);
               rd_addr_in = ADDR_W'(1);
               state_in   = S_PROBE;
            end
         end
         S_PROBE: begin
            // Entry hi is in rd_data_ff.
            if (rd_data_ff < key_ff) begin
               if (hi_doubled >= (ADDR_W + 1)'(cnt_ff)) begin
                  hi_in    = ADDR_W'(cnt_ff - CNT_W'(1));
                  lo_in    = ADDR_W'((cnt_ff - CNT_W'(1)) >> 1);
                  state_in = S_BSTEP;
               end else begin
                  hi_in      = hi_doubled[ADDR_W-1:0];
                  rd_addr_in = hi_doubled[ADDR_W-1:0];
               end
            end else begin
               lo_in    = hi_ff >> 1;
               state_in = S_BSTEP;
            end
         end
         S_BSTEP: begin
            if (bracket_open) begin
               mid_in     = bracket_sum[ADDR_W:1];
               rd_addr_in = bracket_sum[ADDR_W:1];
               state_in   = S_BIN;
            end else begin
               rd_addr_in = lo_ff;
               state_in   = S_LO;
            end
         end
         S_BIN: begin
            if (rd_data_ff < key_ff) begin
               lo_in    = mid_ff;
               state_in = S_BSTEP;
            end else if (rd_data_ff > key_ff) begin
               hi_in    = mid_ff;
               state_in = S_BSTEP;
            end else begin
               res_in   = mid_ff;
               state_in = S_DONE;
            end
         end
         S_LO: begin
            dist_lo_in = dist_now;
            rd_addr_in = hi_ff;
            state_in   = S_HI;
         end
         S_HI: begin
            res_in   = (dist_lo_ff <= dist_now) ? lo_ff : hi_ff;
            state_in = S_DONE;
         end
         S_DONE: begin
            // Wait until the output register is free, or frees this cycle.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         entry_count_ff <= CNT_W'(nvis_pkg::ENTRY_COUNT_RESET);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cnt_ff       <= cnt_in;
      key_ff       <= key_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      res_ff       <= res_in;
      dist_lo_ff   <= dist_lo_in;
      rsp_index_ff <= rsp_index_in;
   end

   // The probe never reads past the last entry in use.
   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE) |-> ({1'b0, hi_ff} < (ADDR_W + 1)'(cnt_ff)))
      else $error("probe index beyond the entries in use");

   // The bisection bracket always keeps its lower end below its upper end.
   a_bracket_ordered: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BSTEP) |-> (lo_ff < hi_ff))
      else $error("bisection bracket collapsed or inverted");

   // A finished search names an entry in use.
   a_result_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> ({1'b0, res_ff} < (ADDR_W + 1)'(cnt_ff)))
      else $error("search result beyond the entries in use");

   // A response only appears when a search has just finished.
   a_rsp_from_search: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised without a finished search");

endmodule
